/* src/crp_pkg.sv */
// ----------------------------------------------------------------------------
// crp_pkg - shared types and constants of the CAT reply parser and poller
// Item layouts, reply head codes, mode codes and default register values.
// ----------------------------------------------------------------------------
package crp_pkg;

  // default line buffer capacity, one more than the visible bytes kept
  localparam int unsigned LineCapDef = 128;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgDataW-1:0] PollIntervalRst = 16'd1000;
  localparam logic [CfgDataW-1:0] ReplyTimeoutRst = 16'd500;

  // characters of the protocol
  localparam logic [7:0] ChSemi = 8'h3B;
  localparam logic [7:0] ChNul  = 8'h00;
  localparam logic [7:0] Ch0    = 8'h30;
  localparam logic [7:0] Ch1    = 8'h31;
  localparam logic [7:0] Ch2    = 8'h32;
  localparam logic [7:0] Ch3    = 8'h33;
  localparam logic [7:0] Ch4    = 8'h34;
  localparam logic [7:0] Ch5    = 8'h35;
  localparam logic [7:0] Ch6    = 8'h36;
  localparam logic [7:0] Ch7    = 8'h37;
  localparam logic [7:0] Ch9    = 8'h39;
  localparam logic [7:0] ChA    = 8'h41;
  localparam logic [7:0] ChB    = 8'h42;
  localparam logic [7:0] ChC    = 8'h43;
  localparam logic [7:0] ChD    = 8'h44;
  localparam logic [7:0] ChF    = 8'h46;
  localparam logic [7:0] ChI    = 8'h49;
  localparam logic [7:0] ChM    = 8'h4D;
  localparam logic [7:0] ChP    = 8'h50;
  localparam logic [7:0] ChS    = 8'h53;
  localparam logic [7:0] ChT    = 8'h54;
  localparam logic [7:0] ChX    = 8'h58;

  // positions inside a reply
  localparam int unsigned PttCharIdx  = 28;
  localparam int unsigned IfDigitLast = 12;
  localparam int unsigned HeadLen     = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_POLL_INTERVAL = 2'd0,
    CFG_REPLY_TIMEOUT = 2'd1
  } cfg_idx_e;

  typedef enum logic {
    ACT_BYTE = 1'b0,
    ACT_TICK = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    POLL_NONE = 2'd0,
    POLL_IF   = 2'd1,
    POLL_SM   = 2'd2
  } poll_cmd_e;

  typedef enum logic [3:0] {
    MODE_LSB     = 4'd0,
    MODE_USB     = 4'd1,
    MODE_AM      = 4'd2,
    MODE_CW      = 4'd3,
    MODE_RTTY    = 4'd4,
    MODE_FM      = 4'd5,
    MODE_CWR     = 4'd7,
    MODE_UNKNOWN = 4'd15
  } mode_e;

  typedef enum logic [2:0] {
    HEAD_FREQ,
    HEAD_MD,
    HEAD_TX,
    HEAD_SM,
    HEAD_PC,
    HEAD_IF,
    HEAD_ID,
    HEAD_OTHER
  } head_e;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] frequency;
    logic [3:0]  mode;
    logic        ptt;
    logic [31:0] smeter;
    logic [31:0] rf_power;
    logic        connected;
    logic        link_ok;
    logic [1:0]  poll_command;
    logic        waiting_reply;
    logic        frame_done;
  } out_item_t;

  // what the line assembler hands over when a reply closes
  typedef struct packed {
    head_e       head;
    logic        long_enough;
    logic        has_char28;
    logic        char28_one;
    logic [31:0] accum;
    logic [3:0]  mode;
    logic        tx_ptt;
  } line_info_t;

  function automatic logic [3:0] mode_code(input logic [7:0] c);
    logic [3:0] m;
    case (c)
      Ch1:     m = MODE_LSB;
      Ch2:     m = MODE_USB;
      Ch3:     m = MODE_CW;
      Ch4:     m = MODE_FM;
      Ch5:     m = MODE_AM;
      Ch6:     m = MODE_RTTY;
      Ch7:     m = MODE_CWR;
      default: m = MODE_UNKNOWN;
    endcase
    return m;
  endfunction

endpackage

/* src/cat_reply_parser_poller.sv */
// ----------------------------------------------------------------------------
// cat_reply_parser_poller - CAT reply parser and poller
// Parses ';'-terminated two-letter replies and raises timed IF/SM polls.
// ----------------------------------------------------------------------------
// Each accepted item (a received byte or a millisecond tick) yields exactly one
// result item, registered in the cycle after acceptance. A new item is taken every
// cycle as long as the result register is empty or being emptied in the same
// cycle, so the sustained rate is one item per clock; the single result
// register is the only buffering. Configuration writes are always ready and
// take effect on the next item.
module cat_reply_parser_poller import crp_pkg::*; #(
  parameter int unsigned LINE_CAP = LineCapDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [CfgDataW-1:0] poll_interval_q, reply_timeout_q;

  logic [31:0] now_q, now_d;
  logic [31:0] last_poll_q, last_poll_d;
  logic [31:0] last_rx_q, last_rx_d;
  logic [31:0] last_update_q, last_update_d;
  logic        poll_sel_q, poll_sel_d;
  logic        waiting_q, waiting_d;
  logic [31:0] freq_q, freq_d;
  logic [3:0]  mode_q, mode_d;
  logic        ptt_q, ptt_d;
  logic [31:0] smeter_q, smeter_d;
  logic [31:0] power_q, power_d;
  logic        connected_q, connected_d;

  logic      out_valid_q;
  out_item_t out_item_q, out_item_d;

  logic        accept;
  logic        is_byte;
  logic        is_term;
  logic [17:0] limit;
  logic [31:0] now_inc;
  logic        poll_fire;
  poll_cmd_e   poll_cmd;
  line_info_t  line_info;

  assign accept  = in_valid_i && in_ready_o;
  assign is_byte = (in_item_i.action == ACT_BYTE);
  assign is_term = is_byte && (in_item_i.rx_byte == ChSemi);

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;

  crp_line #(
    .LINE_CAP (LINE_CAP)
  ) u_line (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_en_i   (accept && is_byte && !is_term),
    .finish_en_i (accept && is_term),
    .rx_byte_i   (in_item_i.rx_byte),
    .info_o      (line_info)
  );

  // three reply timeouts
  assign limit   = {2'b00, reply_timeout_q} + {1'b0, reply_timeout_q, 1'b0};
  assign now_inc = now_q + 32'd1;

  always_comb begin
    now_d         = now_q;
    last_poll_d   = last_poll_q;
    last_rx_d     = last_rx_q;
    last_update_d = last_update_q;
    poll_sel_d    = poll_sel_q;
    waiting_d     = waiting_q;
    freq_d        = freq_q;
    mode_d        = mode_q;
    ptt_d         = ptt_q;
    smeter_d      = smeter_q;
    power_d       = power_q;
    connected_d   = connected_q;
    poll_cmd      = POLL_NONE;
    poll_fire     = (now_inc - last_poll_q) >= {16'd0, poll_interval_q};

    if (!is_byte) begin
      now_d = now_inc;
      if (poll_fire) begin
        poll_cmd    = poll_sel_q ? POLL_SM : POLL_IF;
        poll_sel_d  = !poll_sel_q;
        last_poll_d = now_inc;
        waiting_d   = 1'b1;
      end
      if (waiting_d && ((now_inc - last_poll_d) > {16'd0, reply_timeout_q})) begin
        waiting_d = 1'b0;
      end
      if ((now_inc - last_rx_q) > {14'd0, limit}) begin
        connected_d = 1'b0;
      end
    end else if (is_term) begin
      waiting_d = 1'b0;
      if (line_info.long_enough) begin
        last_rx_d = now_q;
        case (line_info.head)
          HEAD_FREQ: begin
            freq_d        = line_info.accum;
            last_update_d = now_q;
          end
          HEAD_MD:   mode_d = line_info.mode;
          HEAD_TX:   ptt_d = line_info.tx_ptt;
          HEAD_SM:   smeter_d = line_info.accum;
          HEAD_PC:   power_d = line_info.accum;
          HEAD_IF: begin
            freq_d = line_info.accum;
            if (line_info.has_char28) ptt_d = line_info.char28_one;
            last_update_d = now_q;
            connected_d   = 1'b1;
          end
          HEAD_ID:   connected_d = 1'b1;
          default:   ;
        endcase
      end
    end

    out_item_d.frequency     = freq_d;
    out_item_d.mode          = mode_d;
    out_item_d.ptt           = ptt_d;
    out_item_d.smeter        = smeter_d;
    out_item_d.rf_power      = power_d;
    out_item_d.connected     = connected_d;
    out_item_d.link_ok       = connected_d && ((now_d - last_update_d) < {14'd0, limit});
    out_item_d.poll_command  = poll_cmd;
    out_item_d.waiting_reply = waiting_d;
    out_item_d.frame_done    = is_term;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_interval_q <= PollIntervalRst;
      reply_timeout_q <= ReplyTimeoutRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_POLL_INTERVAL: poll_interval_q <= cfg_data_i;
        CFG_REPLY_TIMEOUT: reply_timeout_q <= cfg_data_i;
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q         <= '0;
      last_poll_q   <= '0;
      last_rx_q     <= '0;
      last_update_q <= '0;
      poll_sel_q    <= 1'b0;
      waiting_q     <= 1'b0;
      freq_q        <= '0;
      mode_q        <= '0;
      ptt_q         <= 1'b0;
      smeter_q      <= '0;
      power_q       <= '0;
      connected_q   <= 1'b0;
    end else if (accept) begin
      now_q         <= now_d;
      last_poll_q   <= last_poll_d;
      last_rx_q     <= last_rx_d;
      last_update_q <= last_update_d;
      poll_sel_q    <= poll_sel_d;
      waiting_q     <= waiting_d;
      freq_q        <= freq_d;
      mode_q        <= mode_d;
      ptt_q         <= ptt_d;
      smeter_q      <= smeter_d;
      power_q       <= power_d;
      connected_q   <= connected_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef NO_ASSERTIONS
  // a terminator closes the frame and ends any wait
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_term |=> out_valid_o && out_item_o.frame_done && !out_item_o.waiting_reply)
    else $error("terminator item did not close the frame");

  // a poll always starts a wait
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.poll_command != POLL_NONE) |-> out_item_o.waiting_reply)
    else $error("poll raised without waiting for a reply");

  // link can only be good while connected
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.link_ok |-> out_item_o.connected)
    else $error("link_ok without connection");

  // polls come from ticks, frames from bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.frame_done |-> (out_item_o.poll_command == POLL_NONE))
    else $error("poll and frame end in one item");

  // polls alternate between IF and SM
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !is_byte && poll_fire |=> poll_sel_q != $past(poll_sel_q))
    else $error("poll selection did not alternate");
`endif

endmodule

/* src/crp_line.sv */
// ----------------------------------------------------------------------------
// crp_line - reply line assembler
// Collects the bytes of one reply: head, third character, PTT character and
// the running decimal value, and decodes the head for the closing terminator.
// ----------------------------------------------------------------------------
module crp_line import crp_pkg::*; #(
  parameter int unsigned LINE_CAP = LineCapDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_en_i,
  input  logic       finish_en_i,
  input  logic [7:0] rx_byte_i,
  output line_info_t info_o
);

  localparam int unsigned PosW = $clog2(LINE_CAP);

  logic [PosW-1:0] position_q, position_d;
  logic [7:0]      head_first_q, head_first_d;
  logic [7:0]      head_second_q, head_second_d;
  logic [7:0]      third_char_q, third_char_d;
  logic            char28_q, char28_d;
  logic            digits_live_q, digits_live_d;
  logic            hidden_q, hidden_d;
  logic [31:0]     accum_q, accum_d;

  logic        is_digit;
  logic        head_if;
  logic        in_window;
  logic [31:0] digit_val;

  assign is_digit  = (rx_byte_i >= Ch0) && (rx_byte_i <= Ch9);
  assign head_if   = (head_first_q == ChI) && (head_second_q == ChF);
  assign in_window = !(head_if && (position_q > PosW'(IfDigitLast)));
  assign digit_val = {24'd0, rx_byte_i - Ch0};

  always_comb begin
    position_d    = position_q;
    head_first_d  = head_first_q;
    head_second_d = head_second_q;
    third_char_d  = third_char_q;
    char28_d      = char28_q;
    digits_live_d = digits_live_q;
    hidden_d      = hidden_q;
    accum_d       = accum_q;
    if (finish_en_i) begin
      position_d    = '0;
      head_first_d  = '0;
      head_second_d = '0;
      third_char_d  = '0;
      char28_d      = 1'b0;
      digits_live_d = 1'b1;
      hidden_d      = 1'b0;
      accum_d       = '0;
    end else if (byte_en_i && !hidden_q && (position_q < PosW'(LINE_CAP - 1))) begin
      if (rx_byte_i == ChNul) begin
        // a zero byte hides the rest of the line
        hidden_d      = 1'b1;
        digits_live_d = 1'b0;
      end else begin
        if (position_q == PosW'(0)) head_first_d = rx_byte_i;
        if (position_q == PosW'(1)) head_second_d = rx_byte_i;
        if (position_q == PosW'(HeadLen)) third_char_d = rx_byte_i;
        if (position_q == PosW'(PttCharIdx)) char28_d = (rx_byte_i == Ch1);
        if ((position_q >= PosW'(HeadLen)) && digits_live_q) begin
          if (is_digit && in_window) begin
            accum_d = {accum_q[28:0], 3'b000} + {accum_q[30:0], 1'b0} + digit_val;
          end else begin
            digits_live_d = 1'b0;
          end
        end
        position_d = position_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q    <= '0;
      head_first_q  <= '0;
      head_second_q <= '0;
      third_char_q  <= '0;
      char28_q      <= 1'b0;
      digits_live_q <= 1'b1;
      hidden_q      <= 1'b0;
      accum_q       <= '0;
    end else begin
      position_q    <= position_d;
      head_first_q  <= head_first_d;
      head_second_q <= head_second_d;
      third_char_q  <= third_char_d;
      char28_q      <= char28_d;
      digits_live_q <= digits_live_d;
      hidden_q      <= hidden_d;
      accum_q       <= accum_d;
    end
  end

  always_comb begin
    info_o.head = HEAD_OTHER;
    if (head_first_q == ChF && (head_second_q == ChA || head_second_q == ChB)) begin
      info_o.head = HEAD_FREQ;
    end else if (head_first_q == ChM && head_second_q == ChD) begin
      info_o.head = HEAD_MD;
    end else if (head_first_q == ChT && head_second_q == ChX) begin
      info_o.head = HEAD_TX;
    end else if (head_first_q == ChS && head_second_q == ChM) begin
      info_o.head = HEAD_SM;
    end else if (head_first_q == ChP && head_second_q == ChC) begin
      info_o.head = HEAD_PC;
    end else if (head_if) begin
      info_o.head = HEAD_IF;
    end else if (head_first_q == ChI && head_second_q == ChD) begin
      info_o.head = HEAD_ID;
    end
    info_o.long_enough = (position_q >= PosW'(HeadLen));
    info_o.has_char28  = (position_q > PosW'(PttCharIdx));
    info_o.char28_one  = char28_q;
    info_o.accum       = accum_q;
    info_o.mode        = mode_code(third_char_q);
    info_o.tx_ptt      = (third_char_q == Ch1) || (third_char_q == Ch2);
  end

endmodule
